/* sv/sdcg_pkg.sv */
package sdcg_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned LEN_W  = 24;
  localparam int unsigned CFG_W  = 32;
  localparam int unsigned IDX_W  = 2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_SRC_STRIDE = 2'd2;
  localparam logic [IDX_W-1:0] REG_DST_STRIDE = 2'd3;

  // Input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  // Per-side line geometry: effective width (never zero) and the cursor
  // skip applied at line end, stride minus effective width mod 2^32.
  typedef struct packed {
    logic [LEN_W-1:0]  width;
    logic [ADDR_W-1:0] skip;
  } sdcg_line_cfg_t;

  // Width zero behaves as width one.
  function automatic logic [LEN_W-1:0] eff_width(input logic [LEN_W-1:0] w);
    eff_width = (w == '0) ? LEN_W'(1) : w;
  endfunction

endpackage

/* sv/sdcg_cfg_regs.sv */
module sdcg_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sdcg_pkg::IDX_W-1:0]    cfg_index,
  input  logic [sdcg_pkg::CFG_W-1:0]    cfg_wdata,
  output sdcg_pkg::sdcg_line_cfg_t      src_cfg,
  output sdcg_pkg::sdcg_line_cfg_t      dst_cfg
);
  import sdcg_pkg::*;

  logic [LEN_W-1:0]  src_width_r,  src_width_nxt;
  logic [LEN_W-1:0]  dst_width_r,  dst_width_nxt;
  logic [ADDR_W-1:0] src_stride_r, src_stride_nxt;
  logic [ADDR_W-1:0] dst_stride_r, dst_stride_nxt;
  logic [ADDR_W-1:0] src_skip_r,   src_skip_nxt;
  logic [ADDR_W-1:0] dst_skip_r,   dst_skip_nxt;

  always_comb begin
    src_width_nxt  = src_width_r;
    dst_width_nxt  = dst_width_r;
    src_stride_nxt = src_stride_r;
    dst_stride_nxt = dst_stride_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_SRC_WIDTH:  src_width_nxt  = eff_width(cfg_wdata[LEN_W-1:0]);
        REG_DST_WIDTH:  dst_width_nxt  = eff_width(cfg_wdata[LEN_W-1:0]);
        REG_SRC_STRIDE: src_stride_nxt = cfg_wdata[ADDR_W-1:0];
        REG_DST_STRIDE: dst_stride_nxt = cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
    // Skip follows the new values in the same edge as the write.
    src_skip_nxt = src_stride_nxt - {{(ADDR_W-LEN_W){1'b0}}, src_width_nxt};
    dst_skip_nxt = dst_stride_nxt - {{(ADDR_W-LEN_W){1'b0}}, dst_width_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= LEN_W'(1);
      dst_width_r  <= LEN_W'(1);
      src_stride_r <= ADDR_W'(1);
      dst_stride_r <= ADDR_W'(1);
      src_skip_r   <= '0;
      dst_skip_r   <= '0;
    end else begin
      src_width_r  <= src_width_nxt;
      dst_width_r  <= dst_width_nxt;
      src_stride_r <= src_stride_nxt;
      dst_stride_r <= dst_stride_nxt;
      src_skip_r   <= src_skip_nxt;
      dst_skip_r   <= dst_skip_nxt;
    end
  end

  assign src_cfg = '{width: src_width_r, skip: src_skip_r};
  assign dst_cfg = '{width: dst_width_r, skip: dst_skip_r};

endmodule

/* sv/sdcg_line_side.sv */
module sdcg_line_side (
  input  sdcg_pkg::sdcg_line_cfg_t        line_cfg,
  input  logic [sdcg_pkg::ADDR_W-1:0]     cursor,
  input  logic [sdcg_pkg::LEN_W-1:0]      offset,
  input  logic [sdcg_pkg::LEN_W-1:0]      chunk,
  output logic [sdcg_pkg::LEN_W-1:0]      room,
  output logic [sdcg_pkg::ADDR_W-1:0]     cursor_nxt,
  output logic [sdcg_pkg::LEN_W-1:0]      offset_nxt
);
  import sdcg_pkg::*;

  logic [LEN_W:0] off_sum;
  logic           line_end;

  // Offset at or past a narrowed width gets one byte of room.
  assign room = (offset < line_cfg.width) ? (line_cfg.width - offset) : LEN_W'(1);

  always_comb begin
    off_sum  = {1'b0, offset} + {1'b0, chunk};
    line_end = (off_sum >= {1'b0, line_cfg.width});

    offset_nxt = line_end ? '0 : off_sum[LEN_W-1:0];
    cursor_nxt = cursor + {{(ADDR_W-LEN_W){1'b0}}, chunk}
               + (line_end ? line_cfg.skip : '0);
  end

endmodule

/* sv/strided_dma_chunk_generator_unit.sv */
// Channel | Handshake            | Payload
// --------+----------------------+-----------------------------------------------
// in      | in_valid / in_stall  | in_op, in_src_base, in_dst_base, in_byte_length
// out     | out_valid / out_stall| out_chunk_src_addr, out_chunk_dst_addr,
//         |                      | out_chunk_len, out_last_chunk
// cfg     | cfg_we               | cfg_index, cfg_wdata (write only)
//
// An accepted item is held in the input register; for a next item of a live
// transfer, its chunk is then computed and written to the result register.
// One item is taken every cycle while out does not stall; the loop through
// the cursor, offset and length registers sets that rate.
// Reset (rst_n low, synchronous) empties both registers and idles the transfer.
// A stall on out holds the result register and, through it, the input register.
module strided_dma_chunk_generator_unit (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          cfg_we,
  input  logic [sdcg_pkg::IDX_W-1:0]    cfg_index,
  input  logic [sdcg_pkg::CFG_W-1:0]    cfg_wdata,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [sdcg_pkg::ADDR_W-1:0]   in_src_base,
  input  logic [sdcg_pkg::ADDR_W-1:0]   in_dst_base,
  input  logic [sdcg_pkg::LEN_W-1:0]    in_byte_length,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sdcg_pkg::ADDR_W-1:0]   out_chunk_src_addr,
  output logic [sdcg_pkg::ADDR_W-1:0]   out_chunk_dst_addr,
  output logic [sdcg_pkg::LEN_W-1:0]    out_chunk_len,
  output logic                          out_last_chunk
);
  import sdcg_pkg::*;

  sdcg_line_cfg_t src_cfg, dst_cfg;

  // Input register
  logic              a_valid_r, a_valid_nxt;
  logic              a_op_r;
  logic [ADDR_W-1:0] a_src_r;
  logic [ADDR_W-1:0] a_dst_r;
  logic [LEN_W-1:0]  a_len_r;

  // Transfer state
  logic [ADDR_W-1:0] src_cursor_r, src_cursor_nxt;
  logic [ADDR_W-1:0] dst_cursor_r, dst_cursor_nxt;
  logic [LEN_W-1:0]  src_off_r,    src_off_nxt;
  logic [LEN_W-1:0]  dst_off_r,    dst_off_nxt;
  logic [LEN_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic              busy_r,       busy_nxt;

  // Result register
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_src_r;
  logic [ADDR_W-1:0] out_dst_r;
  logic [LEN_W-1:0]  out_len_r;
  logic              out_last_r;

  logic              out_free;
  logic              a_adv;
  logic              in_take;
  logic              emit;
  logic [LEN_W-1:0]  src_room, dst_room;
  logic [LEN_W-1:0]  chunk;
  logic [ADDR_W-1:0] src_adv_cursor, dst_adv_cursor;
  logic [LEN_W-1:0]  src_adv_off, dst_adv_off;

  sdcg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .src_cfg   (src_cfg),
    .dst_cfg   (dst_cfg)
  );

  sdcg_line_side u_src (
    .line_cfg   (src_cfg),
    .cursor     (src_cursor_r),
    .offset     (src_off_r),
    .chunk      (chunk),
    .room       (src_room),
    .cursor_nxt (src_adv_cursor),
    .offset_nxt (src_adv_off)
  );

  sdcg_line_side u_dst (
    .line_cfg   (dst_cfg),
    .cursor     (dst_cursor_r),
    .offset     (dst_off_r),
    .chunk      (chunk),
    .room       (dst_room),
    .cursor_nxt (dst_adv_cursor),
    .offset_nxt (dst_adv_off)
  );

  // The result register frees up when empty or when its item is taken.
  assign out_free = !out_valid_r || !out_stall;
  assign a_adv    = a_valid_r && out_free;
  assign in_stall = a_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Only a next item during a live transfer yields a descriptor.
  assign emit = a_adv && (a_op_r == OP_NEXT) && busy_r;

  always_comb begin
    chunk = bytes_left_r;
    if (src_room < chunk) begin
      chunk = src_room;
    end
    if (dst_room < chunk) begin
      chunk = dst_room;
    end
  end

  always_comb begin
    a_valid_nxt    = in_take || (a_valid_r && !a_adv);
    src_cursor_nxt = src_cursor_r;
    dst_cursor_nxt = dst_cursor_r;
    src_off_nxt    = src_off_r;
    dst_off_nxt    = dst_off_r;
    bytes_left_nxt = bytes_left_r;
    busy_nxt       = busy_r;
    if (a_adv && (a_op_r == OP_START)) begin
      // Load a new transfer, dropping any running one.
      src_cursor_nxt = a_src_r;
      dst_cursor_nxt = a_dst_r;
      src_off_nxt    = '0;
      dst_off_nxt    = '0;
      bytes_left_nxt = a_len_r;
      busy_nxt       = (a_len_r != '0);
    end else if (emit) begin
      src_cursor_nxt = src_adv_cursor;
      dst_cursor_nxt = dst_adv_cursor;
      src_off_nxt    = src_adv_off;
      dst_off_nxt    = dst_adv_off;
      bytes_left_nxt = bytes_left_r - chunk;
      busy_nxt       = (chunk != bytes_left_r);
    end
    out_valid_nxt = out_free ? emit : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      busy_r       <= 1'b0;
      src_cursor_r <= '0;
      dst_cursor_r <= '0;
      src_off_r    <= '0;
      dst_off_r    <= '0;
      bytes_left_r <= '0;
    end else begin
      a_valid_r    <= a_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      busy_r       <= busy_nxt;
      src_cursor_r <= src_cursor_nxt;
      dst_cursor_r <= dst_cursor_nxt;
      src_off_r    <= src_off_nxt;
      dst_off_r    <= dst_off_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  // Payload registers: capture on handshake, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      a_op_r  <= in_op;
      a_src_r <= in_src_base;
      a_dst_r <= in_dst_base;
      a_len_r <= in_byte_length;
    end
    if (emit) begin
      out_src_r  <= src_cursor_r;
      out_dst_r  <= dst_cursor_r;
      out_len_r  <= chunk;
      out_last_r <= (chunk == bytes_left_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_chunk_src_addr = out_src_r;
  assign out_chunk_dst_addr = out_dst_r;
  assign out_chunk_len      = out_len_r;
  assign out_last_chunk     = out_last_r;

endmodule
